// File: rtl/wesd_pkg.sv
`timescale 1ns / 1ps
package wesd_pkg;

  localparam int WSIZE_W = 16;
  localparam int THR_W   = 31;
  localparam int COUNT_W = WSIZE_W + 1;
  localparam int PROD_W  = THR_W + COUNT_W;
  localparam int SEG_W   = 32;

  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 16'd480;
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = 31'd1073742;

  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE      = 1'b0,
    CFG_ENERGY_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic vld;
    logic last;
  } win_ctl_t;

endpackage

// File: rtl/wesd_seg.sv
`timescale 1ns / 1ps
module wesd_seg
  import wesd_pkg::*;
#(
  parameter int INDEX_BITS  = 32,
  parameter int ENERGY_BITS = 46
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  win_ctl_t               rec_ctl,
  input  logic [ENERGY_BITS-1:0] rec_sum,
  input  logic [COUNT_W-1:0]     rec_cnt,
  input  logic [INDEX_BITS-1:0]  rec_wstart,
  input  logic [INDEX_BITS-1:0]  rec_wend,
  input  logic [THR_W-1:0]       thr,
  output logic                   adv,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [2*SEG_W-1:0]     out_tdata   // seg_start, seg_end
);

  localparam int CMP_W = (ENERGY_BITS > PROD_W) ? ENERGY_BITS : PROD_W;

  win_ctl_t               p_ctl_r;
  logic [PROD_W-1:0]      p_prod_r;
  logic [ENERGY_BITS-1:0] p_sum_r;
  logic [INDEX_BITS-1:0]  p_wstart_r;
  logic [INDEX_BITS-1:0]  p_wend_r;

  logic                   in_sp_r, in_sp_nxt;
  logic [INDEX_BITS-1:0]  sb_r, sb_nxt;

  logic                   out_vld_r, out_vld_nxt;
  logic [2*SEG_W-1:0]     out_data_r, out_data_nxt;
  logic                   skid_vld_r, skid_vld_nxt;
  logic [2*SEG_W-1:0]     skid_data_r, skid_data_nxt;

  logic                   speech;
  logic                   res;
  logic                   res_vld;
  logic [INDEX_BITS-1:0]  res_start;
  logic [INDEX_BITS-1:0]  res_end;
  logic [INDEX_BITS+SEG_W-1:0] start_ext;
  logic [INDEX_BITS+SEG_W-1:0] end_ext;
  logic                   take;

  assign adv = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
    end else if (adv) begin
      p_ctl_r <= rec_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_prod_r   <= PROD_W'(thr) * PROD_W'(rec_cnt);
      p_sum_r    <= rec_sum;
      p_wstart_r <= rec_wstart;
      p_wend_r   <= rec_wend;
    end
  end

  always_comb begin
    speech    = CMP_W'(p_sum_r) > CMP_W'(p_prod_r);
    in_sp_nxt = in_sp_r;
    sb_nxt    = sb_r;
    res       = 1'b0;
    res_start = sb_r;
    res_end   = p_wstart_r;
    if (p_ctl_r.vld) begin
      if (speech && !in_sp_r) begin
        in_sp_nxt = 1'b1;
        sb_nxt    = p_wstart_r;
      end else if (!speech && in_sp_r) begin
        in_sp_nxt = 1'b0;
        res       = 1'b1;
      end
      if (p_ctl_r.last && in_sp_nxt) begin
        res       = 1'b1;
        res_start = sb_nxt;
        res_end   = p_wend_r;
      end
      if (p_ctl_r.last) begin
        in_sp_nxt = 1'b0;
        sb_nxt    = '0;
      end
    end
  end

  assign res_vld   = adv && res;
  assign start_ext = {{SEG_W{1'b0}}, res_start};
  assign end_ext   = {{SEG_W{1'b0}}, res_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sp_r <= 1'b0;
      sb_r    <= '0;
    end else if (adv) begin
      in_sp_r <= in_sp_nxt;
      sb_r    <= sb_nxt;
    end
  end

  // output word register plus one skid word
  assign take = out_vld_r && out_tready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (take) begin
      if (skid_vld_r) begin
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = res_vld;
        out_data_nxt = {end_ext[SEG_W-1:0], start_ext[SEG_W-1:0]};
      end
    end else if (res_vld) begin
      if (!out_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = {end_ext[SEG_W-1:0], start_ext[SEG_W-1:0]};
      end else begin
        skid_vld_nxt  = 1'b1;
        skid_data_nxt = {end_ext[SEG_W-1:0], start_ext[SEG_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held with empty output register");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && p_ctl_r.vld && p_ctl_r.last) |=> (!in_sp_r && sb_r == '0))
    else $error("speech state not cleared after last window");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(in_sp_r) && $stable(sb_r)))
    else $error("segment state moved while stalled");

endmodule

// File: rtl/windowed_energy_speech_detector_core.sv
`timescale 1ns / 1ps
// Path: a closing sample passes the magnitude, square, record, product and output registers.
// Throughput: one sample per cycle unless a skid word is held; the accumulator loop (sum, fill
// count, index) has no inner stage; the square and threshold product each own a stage.
// Reset (rst_n, synchronous, active low): pipeline and recording state cleared,
// window_size = 480, energy_threshold = 1073742.
module windowed_energy_speech_detector_core
  import wesd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // sample
  input  logic                                  in_tlast,   // last
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [2*SEG_W-1:0]                    out_tdata,  // seg_start, seg_end
  input  logic                                  cfg_wr_en,
  input  cfg_reg_t                              cfg_addr,
  input  logic [THR_W-1:0]                      cfg_wdata
);

  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int ENERGY_BITS = 2 * SAMPLE_BITS + 14;

  logic                   adv;

  logic [WSIZE_W-1:0]     ws_r;
  logic [THR_W-1:0]       thr_r;

  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] mag;

  logic                   s1_vld_r, s1_last_r;
  logic [SAMPLE_BITS-1:0] s1_mag_r;
  logic                   s2_vld_r, s2_last_r;
  logic [SQ_W-1:0]        s2_sq_r;

  logic [ENERGY_BITS-1:0] sum_r, sum_nxt;
  logic [WSIZE_W-1:0]     fill_r, fill_nxt;
  logic [INDEX_BITS-1:0]  idx_r, idx_nxt;
  logic [INDEX_BITS-1:0]  wbeg_r, wbeg_nxt;

  logic [ENERGY_BITS-1:0] sum_acc;
  logic [WSIZE_W-1:0]     fill_inc;
  logic [INDEX_BITS-1:0]  idx_inc;
  logic [WSIZE_W-1:0]     wsize_eff;
  logic                   win_end;

  win_ctl_t               rec_ctl_r, rec_ctl_nxt;
  logic [ENERGY_BITS-1:0] rec_sum_r;
  logic [COUNT_W-1:0]     rec_cnt_r;
  logic [INDEX_BITS-1:0]  rec_wstart_r;
  logic [INDEX_BITS-1:0]  rec_wend_r;

  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r  <= WINDOW_SIZE_RST;
      thr_r <= THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_WINDOW_SIZE:      ws_r  <= cfg_wdata[WSIZE_W-1:0];
        CFG_ENERGY_THRESHOLD: thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sample = in_tdata[SAMPLE_BITS-1:0];
  assign mag    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag_r  <= mag;
      s1_last_r <= in_tlast;
      s2_sq_r   <= SQ_W'(s1_mag_r) * SQ_W'(s1_mag_r);
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    sum_acc   = sum_r + ENERGY_BITS'(s2_sq_r);
    fill_inc  = fill_r + 1'b1;
    idx_inc   = idx_r + 1'b1;
    wsize_eff = (ws_r == '0) ? WSIZE_W'(1) : ws_r;
    win_end   = s2_vld_r && ((fill_inc >= wsize_eff) || (fill_inc == '0) || s2_last_r);

    sum_nxt  = sum_r;
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    wbeg_nxt = wbeg_r;
    if (s2_vld_r) begin
      if (win_end) begin
        sum_nxt  = '0;
        fill_nxt = '0;
        idx_nxt  = s2_last_r ? '0 : idx_inc;
        wbeg_nxt = s2_last_r ? '0 : idx_inc;
      end else begin
        sum_nxt  = sum_acc;
        fill_nxt = fill_inc;
        idx_nxt  = idx_inc;
      end
    end
    rec_ctl_nxt.vld  = win_end;
    rec_ctl_nxt.last = s2_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      fill_r    <= '0;
      idx_r     <= '0;
      wbeg_r    <= '0;
      rec_ctl_r <= '0;
    end else if (adv) begin
      sum_r     <= sum_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      wbeg_r    <= wbeg_nxt;
      rec_ctl_r <= rec_ctl_nxt;
    end
  end

  // a full 16-bit wrap of the fill count means 65536 samples
  always_ff @(posedge clk) begin
    if (adv) begin
      rec_sum_r    <= sum_acc;
      rec_cnt_r    <= {(fill_inc == '0), fill_inc};
      rec_wstart_r <= wbeg_r;
      rec_wend_r   <= idx_inc;
    end
  end

  wesd_seg #(
    .INDEX_BITS  (INDEX_BITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_seg (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_ctl    (rec_ctl_r),
    .rec_sum    (rec_sum_r),
    .rec_cnt    (rec_cnt_r),
    .rec_wstart (rec_wstart_r),
    .rec_wend   (rec_wend_r),
    .thr        (thr_r),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r && s2_last_r) |=> (fill_r == '0 && idx_r == '0 && sum_r == '0))
    else $error("recording state not cleared after last sample");

  a_last_ends_window: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r && s2_last_r) |=> (rec_ctl_r.vld && rec_ctl_r.last))
    else $error("last sample did not close its window");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !in_tvalid) |=> !s1_vld_r)
    else $error("pipeline took a word without a handshake");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import wesd_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 150;

  localparam int KIND_LOUD  = 0;
  localparam int KIND_QUIET = 1;
  localparam int KIND_NOISE = 2;

  typedef struct packed {
    logic [SEG_W-1:0] seg_end;
    logic [SEG_W-1:0] seg_start;
  } segment_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;   // sample
  logic             in_tlast;   // last
  logic             out_tvalid;
  logic             out_tready;
  logic [2*SEG_W-1:0] out_tdata;  // seg_start, seg_end
  logic             cfg_wr_en;
  cfg_reg_t         cfg_addr;
  logic [THR_W-1:0] cfg_wdata;

  windowed_energy_speech_detector_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // detector model state
  logic [WSIZE_W-1:0] cur_wsize;
  logic [THR_W-1:0]   cur_thr;
  logic [45:0]        acc_energy;
  logic [15:0]        acc_fill;
  logic [31:0]        next_index;
  logic [31:0]        win_start;
  logic               talking;
  logic [31:0]        talk_start;

  segment_t segments_due[$];

  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit gaps_on = 1;
  int hold_req = 0;
  int rand_items = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input segment_t exp_seg,
                               input segment_t got_seg);
    err_count++;
    if (err_count <= 10)
      $display("mismatch (%s) at %0t: expected start %0d end %0d, got start %0d end %0d",
               what, $realtime, exp_seg.seg_start, exp_seg.seg_end,
               got_seg.seg_start, got_seg.seg_end);
  endtask

  always @(posedge clk) begin
    segment_t got_seg;
    segment_t exp_seg;
    if (rst_n && out_tvalid && out_tready) begin
      got_seg = out_tdata;
      if (segments_due.size() == 0) begin
        note_mismatch("unexpected word", '0, got_seg);
      end else begin
        exp_seg = segments_due.pop_front();
        if (got_seg.seg_start !== exp_seg.seg_start)
          note_mismatch("seg_start", exp_seg, got_seg);
        if (got_seg.seg_end !== exp_seg.seg_end)
          note_mismatch("seg_end", exp_seg, got_seg);
      end
    end
  end

  // receiver: stall pattern, plus long hold-offs on request
  initial begin
    int hold_left;
    int pattern_left;
    logic [7:0] ready_mask;
    logic [2:0] phase;
    hold_left = 0;
    pattern_left = 0;
    ready_mask = 8'hFF;
    phase = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
          if (ready_mask == 8'h00)
            ready_mask = 8'h01;
        end
        pattern_left--;
        out_tready <= ready_mask[phase];
        phase = phase + 3'd1;
      end
    end
  end

  task automatic clear_recording();
    acc_energy = '0;
    acc_fill = '0;
    next_index = '0;
    win_start = '0;
    talking = 1'b0;
    talk_start = '0;
  endtask

  task automatic queue_segment(input segment_t seg);
    segments_due.insert(segments_due.size(), seg);
  endtask

  task automatic track_sample(input logic signed [15:0] smp, input logic lst);
    logic [16:0] mag;
    logic [33:0] sq;
    logic [16:0] wsz;
    logic [16:0] count;
    logic [47:0] bound;
    logic speech;
    segment_t seg;
    mag = (smp < 0) ? 17'(-int'(smp)) : 17'(int'(smp));
    sq = 34'(mag) * 34'(mag);
    acc_energy = acc_energy + 46'(sq);
    acc_fill = acc_fill + 16'd1;
    next_index = next_index + 32'd1;
    wsz = (cur_wsize == '0) ? 17'd1 : {1'b0, cur_wsize};
    if ({1'b0, acc_fill} >= wsz || acc_fill == '0 || lst) begin
      count = (acc_fill == '0) ? 17'h10000 : {1'b0, acc_fill};
      bound = 48'(cur_thr) * 48'(count);
      speech = {2'b00, acc_energy} > bound;
      if (speech && !talking) begin
        talking = 1'b1;
        talk_start = win_start;
      end else if (!speech && talking) begin
        talking = 1'b0;
        seg.seg_start = talk_start;
        seg.seg_end = win_start;
        queue_segment(seg);
      end
      if (lst && talking) begin
        seg.seg_start = talk_start;
        seg.seg_end = next_index;
        queue_segment(seg);
      end
      acc_energy = '0;
      acc_fill = '0;
      win_start = next_index;
      if (lst)
        clear_recording();
    end
  endtask

  task automatic send_sample(input logic signed [15:0] smp, input logic lst);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tlast <= lst;
    do @(posedge clk); while (in_tready !== 1'b1);
    track_sample(smp, lst);
  endtask

  task automatic settle_idle(input int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (segments_due.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_config(input logic [WSIZE_W-1:0] wsize, input logic [THR_W-1:0] thr);
    settle_idle(SETTLE_CYCLES);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_WINDOW_SIZE;
    cfg_wdata <= THR_W'(wsize);
    @(negedge clk);
    cfg_addr <= CFG_ENERGY_THRESHOLD;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_wsize = wsize;
    cur_thr = thr;
  endtask

  function automatic logic signed [15:0] make_sample(input int kind);
    int mag;
    case (kind)
      KIND_LOUD: begin
        if ($urandom_range(0, 15) == 0)
          return 16'sh8000;
        mag = $urandom_range(8192, 32767);
      end
      KIND_QUIET: mag = $urandom_range(0, 255);
      default: return 16'($urandom);
    endcase
    return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic test_reset_defaults();
    for (int i = 0; i < 480; i++)
      send_sample(make_sample(KIND_LOUD), 1'b0);
    send_sample(make_sample(KIND_QUIET), 1'b1);
  endtask

  task automatic test_extremes();
    set_config(16'd4, 31'h1000_0000);
    repeat (4) send_sample(16'sh8000, 1'b0);
    repeat (4) send_sample(16'sh7fff, 1'b0);
    repeat (4) send_sample(16'sh0000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // zero window size behaves as one
    set_config(16'd0, 31'd0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd7, 1'b1);
    // threshold beyond full scale never detects
    set_config(16'd2, 31'h7fff_ffff);
    repeat (2) send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
  endtask

  task automatic test_window_shrink();
    set_config(16'd8, 31'h0010_0000);
    repeat (5) send_sample(make_sample(KIND_LOUD), 1'b0);
    set_config(16'd3, 31'h0010_0000);
    send_sample(make_sample(KIND_LOUD), 1'b0);
    repeat (2) send_sample(make_sample(KIND_QUIET), 1'b0);
    send_sample(make_sample(KIND_QUIET), 1'b1);
  endtask

  task automatic test_long_window();
    set_config(16'hffff, 31'h0010_0000);
    gaps_on = 0;
    for (int i = 0; i < 40; i++)
      send_sample(make_sample(KIND_NOISE), 1'b0);
    repeat (4) send_sample(make_sample(KIND_QUIET), 1'b0);
    send_sample(make_sample(KIND_QUIET), 1'b1);
    gaps_on = 1;
  endtask

  task automatic test_backpressure();
    set_config(16'd1, 31'h0001_0000);
    gaps_on = 0;
    hold_req = 400;
    for (int i = 0; i < 120; i++)
      send_sample(make_sample((i % 2 == 0) ? KIND_LOUD : KIND_QUIET), i == 119);
    gaps_on = 1;
  endtask

  task automatic play_recording(input bit close_it);
    int n_win;
    int eff;
    int len;
    int kind;
    int pick;
    n_win = $urandom_range(1, 8);
    eff = (cur_wsize == '0) ? 1 : int'(cur_wsize);
    for (int w = 0; w < n_win; w++) begin
      len = (close_it && w == n_win - 1) ? $urandom_range(1, eff) : eff;
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? KIND_LOUD : (pick < 8) ? KIND_QUIET : KIND_NOISE;
      for (int i = 0; i < len; i++) begin
        send_sample(make_sample(kind), close_it && w == n_win - 1 && i == len - 1);
        rand_items++;
      end
    end
  endtask

  task automatic test_random_recordings();
    logic [WSIZE_W-1:0] wsize;
    logic [THR_W-1:0] thr;
    int pick;
    while (rand_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: wsize = 16'd0;
        1: wsize = 16'd1;
        2: wsize = 16'($urandom_range(30, 48));
        default: wsize = 16'($urandom_range(2, 16));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0: thr = 31'd0;
        1: thr = 31'($urandom);
        2: thr = 31'h7fff_ffff;
        default: thr = 31'h0010_0000;
      endcase
      set_config(wsize, thr);
      repeat ($urandom_range(1, 3)) begin
        // some recordings stay open across the next settings change
        play_recording($urandom_range(0, 4) != 0);
        if (rand_items >= RANDOM_ITEMS)
          break;
      end
    end
    play_recording(1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = CFG_WINDOW_SIZE;
    cfg_wdata = '0;
    cur_wsize = WINDOW_SIZE_RST;
    cur_thr = THRESHOLD_RST;
    clear_recording();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extremes();
    test_window_shrink();
    test_backpressure();
    test_long_window();
    test_random_recordings();

    settle_idle(20);
    if (err_count == 0 && segments_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
